/* hw/rtl/upc_pkg.sv */
// ----------------------------------------------------------------------------
// upc_pkg
// Shared types, codes and lookup functions for the URI percent codec.
// ----------------------------------------------------------------------------
`default_nettype none

package upc_pkg;

  // Register indexes on the config port
  localparam logic CFG_DIRECTION = 1'b0;
  localparam logic CFG_COMPONENT = 1'b1;

  // Direction codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // Component codes
  localparam logic [2:0] COMP_USERINFO = 3'd0;
  localparam logic [2:0] COMP_HOST     = 3'd1;
  localparam logic [2:0] COMP_PATH     = 3'd2;
  localparam logic [2:0] COMP_QUERY    = 3'd3;
  localparam logic [2:0] COMP_FRAGMENT = 3'd4;

  // Bytes 0..127 that get escaped on encode; bit i stands for byte i
  localparam logic [127:0] ESC_MASK = 128'hF800000178000001_5C0018BDFFFFFFFF;

  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  // Maximum results per input byte
  localparam int MaxRes = 3;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } res_t;

  function automatic logic in_escape_set(input logic [7:0] b);
    return !b[7] && ESC_MASK[b[6:0]];
  endfunction

  function automatic logic is_exempt(input logic [2:0] comp, input logic [7:0] b);
    logic r;
    case (comp)
      COMP_USERINFO: r = (b == 8'h3A);
      COMP_HOST:     r = (b == 8'h3A) || (b == 8'h5B) || (b == 8'h5D);
      COMP_PATH:     r = (b == 8'h2F) || (b == 8'h2E) || (b == 8'h40) ||
                         (b == 8'h25) || (b == 8'h3B) || (b == 8'h3D);
      COMP_QUERY,
      COMP_FRAGMENT: r = (b == 8'h2F) || (b == 8'h2E) || (b == 8'h40) ||
                         (b == 8'h26) || (b == 8'h25) || (b == 8'h3B) ||
                         (b == 8'h3D);
      default:       r = 1'b0;
    endcase
    return r;
  endfunction

  // Uppercase hex character for a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
  endfunction

  // Bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    if (b >= 8'h30 && b <= 8'h39)      r = {1'b0, b[3:0]};
    else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
      r = {1'b0, b[3:0] + 4'd9};
    else                               r = 5'h10;
    return r;
  endfunction

  function automatic logic [7:0] plain_char(input logic [7:0] b);
    return (b == CH_PLUS) ? CH_SPACE : b;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/uri_percent_codec.sv */
// ----------------------------------------------------------------------------
// uri_percent_codec
// Byte-stream URI percent encoder / decoder selected by a config register.
// ----------------------------------------------------------------------------
// Input bytes arrive on s_axis (tdata = byte, tlast = end of string). Each
// accepted byte is translated in the cycle of acceptance into zero to three
// result beats, held in a three-slot result buffer that drains on m_axis
// (tdata = byte, tuser = byte carries data, tlast = end of string).
// The first result of a byte shows on m_axis in the cycle after the byte is
// accepted. Throughput: one byte per cycle when each byte yields at most one
// result and m_axis does not stall; an encoded escape yields three beats, and
// the next byte waits until they drain. The rate is set by the single m_axis
// port draining the result buffer one beat per cycle while m_axis_tready is
// high. A new byte is taken in the same cycle as the last buffered beat is handed over.
// Decoding keeps a small escape state ('%' seen, high digit seen) across
// bytes; the end of a string always returns it to idle. A string whose last
// byte yields nothing ends with one beat with tuser low and tdata zero.
// Reset (rst, synchronous) empties the buffer, clears the escape state and
// sets encode with the user-info component. When m_axis stalls, the buffer
// holds and s_axis stops taking bytes as soon as any beat is pending.
// Config writes (cfg_we/cfg_index/cfg_data) are to be issued only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module uri_percent_codec
  import upc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,

  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [2:0] cfg_data,

  input  wire logic       s_axis_tvalid,
  output      logic       s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,

  output      logic       m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output      logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output      logic       m_axis_tuser,   // [0] byte_valid
  output      logic       m_axis_tlast
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_HIGH = 2'd2
  } phase_t;

  logic       direction;
  logic [2:0] component;
  phase_t     phase, phase_next;
  logic [3:0] high_digit, high_digit_next;
  logic       high_digit_ok, high_digit_ok_next;

  res_t       slot [MaxRes];
  res_t       res_next [MaxRes];
  logic [1:0] count;
  logic [1:0] n_res;

  logic       accept, take;
  logic [4:0] hv;
  logic [7:0] dv;

  assign take          = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (count == 2'd0) || (count == 2'd1 && m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = (count != 2'd0);
  assign m_axis_tdata  = slot[0].data;
  assign m_axis_tuser  = slot[0].valid;
  assign m_axis_tlast  = slot[0].last;

  assign hv = hex_value(s_axis_tdata);
  assign dv = {high_digit, hv[3:0]};

  // Translate one byte into up to three results
  always_comb begin
    phase_next         = phase;
    high_digit_next    = high_digit;
    high_digit_ok_next = high_digit_ok;
    n_res              = 2'd0;
    for (int i = 0; i < MaxRes; i++) begin
      res_next[i] = '0;
    end

    if (direction == DIR_ENCODE) begin
      phase_next         = PH_IDLE;
      high_digit_next    = 4'h0;
      high_digit_ok_next = 1'b0;
      if (in_escape_set(s_axis_tdata) && !is_exempt(component, s_axis_tdata)) begin
        res_next[0] = '{data: CH_PCT, valid: 1'b1, last: 1'b0};
        res_next[1] = '{data: hex_char(s_axis_tdata[7:4]), valid: 1'b1, last: 1'b0};
        res_next[2] = '{data: hex_char(s_axis_tdata[3:0]), valid: 1'b1, last: 1'b0};
        n_res       = 2'd3;
      end else begin
        res_next[0] = '{data: s_axis_tdata, valid: 1'b1, last: 1'b0};
        n_res       = 2'd1;
      end
    end else begin
      case (phase)
        PH_PCT: begin
          if (s_axis_tlast) begin
            // short escape: '%' goes out literally
            res_next[0] = '{data: CH_PCT, valid: 1'b1, last: 1'b0};
            res_next[1] = '{data: plain_char(s_axis_tdata), valid: 1'b1, last: 1'b0};
            n_res       = 2'd2;
            phase_next  = PH_IDLE;
          end else begin
            high_digit_next    = hv[3:0];
            high_digit_ok_next = !hv[4];
            phase_next         = PH_HIGH;
          end
        end
        PH_HIGH: begin
          if (high_digit_ok && !hv[4] && dv >= CH_SPACE && dv != CH_DEL) begin
            res_next[0] = '{data: dv, valid: 1'b1, last: 1'b0};
            n_res       = 2'd1;
          end
          phase_next         = PH_IDLE;
          high_digit_next    = 4'h0;
          high_digit_ok_next = 1'b0;
        end
        default: begin
          phase_next = PH_IDLE;
          if (s_axis_tdata == CH_PCT) begin
            if (s_axis_tlast) begin
              res_next[0] = '{data: CH_PCT, valid: 1'b1, last: 1'b0};
              n_res       = 2'd1;
            end else begin
              phase_next = PH_PCT;
            end
          end else begin
            res_next[0] = '{data: plain_char(s_axis_tdata), valid: 1'b1, last: 1'b0};
            n_res       = 2'd1;
          end
        end
      endcase
    end

    // End of string: mark the final result, or emit an empty marker
    if (s_axis_tlast) begin
      if (n_res == 2'd0) begin
        n_res = 2'd1;
      end
      res_next[n_res - 2'd1].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction     <= DIR_ENCODE;
      component     <= COMP_USERINFO;
      phase         <= PH_IDLE;
      high_digit    <= 4'h0;
      high_digit_ok <= 1'b0;
      count         <= 2'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DIRECTION: direction <= cfg_data[0];
          CFG_COMPONENT: component <= cfg_data;
          default:       ;
        endcase
      end
      if (accept) begin
        phase         <= phase_next;
        high_digit    <= high_digit_next;
        high_digit_ok <= high_digit_ok_next;
        count         <= n_res;
      end else if (take) begin
        count <= count - 2'd1;
      end
    end
  end

  // Result buffer payload: load on accept, shift toward slot 0 on take
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MaxRes; i++) begin
        slot[i] <= res_next[i];
      end
    end else if (take) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  // A new byte never overwrites beats still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    accept |-> (count == 2'd0) || (count == 2'd1 && take))
    else $error("result buffer overwritten");

  // An empty beat only ever closes a string and carries zero data
  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == 8'h00))
    else $error("empty beat not at end of string");

  // End of string leaves the escape state idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tlast) |=> (phase == PH_IDLE))
    else $error("escape state open after end of string");

  // Encoding never leaves an escape open
  a_encode_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && direction == DIR_ENCODE) |=> (phase == PH_IDLE && !high_digit_ok))
    else $error("escape state open after encode");

endmodule

`default_nettype wire

/* tb/uri_percent_codec_tb.sv */
// ----------------------------------------------------------------------------
// uri_percent_codec_tb
// Self-checking bench for the URI percent codec. A short table of directed
// bytes covers both directions, every component and the escape corner cases
// (short escape, swallowed pair, dropped control byte, empty end beat). It is
// followed by phases of random strings under set, then random, configs, with
// random stalls on both streams and one long output hold-off. Each output beat
// is checked against its table row or against an in-bench model of the codec.
// ----------------------------------------------------------------------------
`default_nettype none

module uri_percent_codec_tb;
  import upc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ROWS    = 25;
  localparam int TOTAL_BYTES = 430;
  localparam int HOLD_CYCLES = 80;
  localparam int LIMIT       = 100000;

  // URI delimiters and marks, picked often for the encode strings
  localparam logic [8*16-1:0] URI_MARKS = ":[]/.@&%;=#?+ ~\"";

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_PCT,
    ESC_HIGH
  } esc_phase_t;

  // one directed byte; when fixed is set, n bytes of e (first byte lowest)
  // are the expected data, with the end-of-string rules applied on top
  typedef struct packed {
    logic       dir;
    logic [2:0] comp;
    logic [7:0] b;
    logic       l;
    logic       fixed;
    logic [1:0] n;
    logic [23:0] e;
  } dir_row_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [2:0] cfg_data;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       m_axis_tlast;

  // typed expectation travels with the input beat
  logic        fix_on;
  logic [1:0]  fix_n;
  logic [23:0] fix_bytes;

  dir_row_t   rows [0:NUM_ROWS-1];
  res_t       beats_due [$];
  logic [7:0] str_q [$];

  // codec model state
  logic       mdl_dir;
  logic [2:0] mdl_comp;
  esc_phase_t mdl_esc;
  logic [3:0] mdl_hi;
  logic       mdl_hi_ok;
  res_t       step_beats [0:2];
  int         step_cnt;

  logic       drv_dir;
  logic [2:0] drv_comp;
  bit         idle_on = 1'b1;
  bit         hold_req = 1'b0;
  int         sent = 0;
  int         mismatches = 0;
  int         cycles = 0;

  uri_percent_codec dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [7:0] hex_glyph(input logic [3:0] v, input logic lower);
    if (v < 4'd10) return 8'h30 + {4'h0, v};
    return (lower ? 8'h57 : 8'h37) + {4'h0, v};
  endfunction

  // bit 4 set: not a hex digit
  function automatic logic [4:0] nibble_of(input logic [7:0] b);
    if (b >= "0" && b <= "9") return {1'b0, 4'(b - 8'h30)};
    if (b >= "a" && b <= "f") return {1'b0, 4'(b - 8'h57)};
    if (b >= "A" && b <= "F") return {1'b0, 4'(b - 8'h37)};
    return 5'h10;
  endfunction

  function automatic logic needs_escape(input logic [7:0] b, input logic [2:0] comp);
    logic hit;
    logic ex;
    hit = (b <= 8'd32) || (b == CH_DEL);
    case (b)
      "\"", "#", "$", "%", "'", "+", ",", ":", ";", "<", ">", "@",
      "[", "\\", "]", "^", 8'h60, "{", "|", "}", "~": hit = 1'b1;
      default: ;
    endcase
    case (comp)
      COMP_USERINFO: ex = (b == ":");
      COMP_HOST:     ex = (b == ":") || (b == "[") || (b == "]");
      COMP_PATH:     ex = (b == "/") || (b == ".") || (b == "@") || (b == "%") ||
                          (b == ";") || (b == "=");
      COMP_QUERY,
      COMP_FRAGMENT: ex = (b == "/") || (b == ".") || (b == "@") || (b == "&") ||
                          (b == "%") || (b == ";") || (b == "=");
      default:       ex = 1'b0;
    endcase
    return hit && !ex;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    str_q.insert(str_q.size(), b);
  endfunction

  function automatic void queue_beat(input res_t r);
    beats_due.insert(beats_due.size(), r);
  endfunction

  function automatic void emit(input logic [7:0] b);
    step_beats[step_cnt] = '{data: b, valid: 1'b1, last: 1'b0};
    step_cnt++;
  endfunction

  // advances the model by one input byte, leaves its beats in step_beats
  function automatic void codec_step(input logic [7:0] b, input logic l);
    logic [4:0] nv;
    logic [7:0] v;
    step_cnt = 0;
    if (mdl_dir == DIR_ENCODE) begin
      mdl_esc   = ESC_IDLE;
      mdl_hi    = 4'h0;
      mdl_hi_ok = 1'b0;
      if (needs_escape(b, mdl_comp)) begin
        emit(CH_PCT);
        emit(hex_glyph(b[7:4], 1'b0));
        emit(hex_glyph(b[3:0], 1'b0));
      end else begin
        emit(b);
      end
    end else begin
      case (mdl_esc)
        ESC_PCT: begin
          if (l) begin
            // '%' with only one byte left goes out as is
            emit(CH_PCT);
            emit(b == CH_PLUS ? CH_SPACE : b);
            mdl_esc = ESC_IDLE;
          end else begin
            nv        = nibble_of(b);
            mdl_hi    = nv[3:0];
            mdl_hi_ok = !nv[4];
            mdl_esc   = ESC_HIGH;
          end
        end
        ESC_HIGH: begin
          nv = nibble_of(b);
          if (mdl_hi_ok && !nv[4]) begin
            v = {mdl_hi, nv[3:0]};
            if (v >= 8'd32 && v != CH_DEL) emit(v);
          end
          mdl_esc   = ESC_IDLE;
          mdl_hi    = 4'h0;
          mdl_hi_ok = 1'b0;
        end
        default: begin
          mdl_esc = ESC_IDLE;
          if (b == CH_PCT) begin
            if (l) emit(CH_PCT);
            else mdl_esc = ESC_PCT;
          end else begin
            emit(b == CH_PLUS ? CH_SPACE : b);
          end
        end
      endcase
    end
    if (l) begin
      if (step_cnt == 0) begin
        step_beats[0] = '{data: 8'h00, valid: 1'b0, last: 1'b0};
        step_cnt = 1;
      end
      step_beats[step_cnt-1].last = 1'b1;
    end
  endfunction

  // ------------------------------------------------------ monitor / checker

  always @(posedge clk) begin : mon
    res_t e;
    if (rst) begin
      mdl_dir   = DIR_ENCODE;
      mdl_comp  = COMP_USERINFO;
      mdl_esc   = ESC_IDLE;
      mdl_hi    = 4'h0;
      mdl_hi_ok = 1'b0;
      beats_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_DIRECTION) mdl_dir = cfg_data[0];
        else mdl_comp = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        codec_step(s_axis_tdata, s_axis_tlast);
        if (fix_on) begin
          for (int i = 0; i < fix_n; i++)
            queue_beat('{data: fix_bytes[8*i +: 8], valid: 1'b1,
                         last: s_axis_tlast && (i == fix_n - 1)});
          if (fix_n == 0 && s_axis_tlast)
            queue_beat('{data: 8'h00, valid: 1'b0, last: 1'b1});
        end else begin
          for (int i = 0; i < step_cnt; i++) queue_beat(step_beats[i]);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (beats_due.size() == 0) begin
          $error("unexpected output beat: out_byte %h byte_valid %b out_last %b",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatches++;
        end else begin
          e = beats_due.pop_front();
          if (m_axis_tdata !== e.data) begin
            $error("out_byte: expected %h, actual %h", e.data, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tuser !== e.valid) begin
            $error("byte_valid: expected %b, actual %b", e.valid, m_axis_tuser);
            mismatches++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("out_last: expected %b, actual %b", e.last, m_axis_tlast);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("uri_percent_codec_tb NOT OK");
      $finish;
    end
  end

  // ----------------------------------------------------------- output side

  initial begin : sink
    int stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------ input side

  task automatic send_beat(input logic [7:0] b, input logic l, input logic fx,
                           input logic [1:0] fn, input logic [23:0] fb);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    fix_on        <= fx;
    fix_n         <= fn;
    fix_bytes     <= fb;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  // wait until every expected beat is out, then cover a byte still in flight
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (beats_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input logic [2:0] dir_val, input logic [2:0] comp_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DIRECTION;
    cfg_data  <= dir_val;
    @(posedge clk);
    cfg_index <= CFG_COMPONENT;
    cfg_data  <= comp_val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    drv_dir  = dir_val[0];
    drv_comp = comp_val;
  endtask

  task automatic fill_string(input logic dec);
    int n;
    str_q.delete();
    if (!dec) begin
      n = $urandom_range(1, 10);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: put_byte(8'($urandom_range(0, 255)));
          1: put_byte(URI_MARKS[8*$urandom_range(0, 15) +: 8]);
          2: put_byte($urandom_range(0, 33) == 33 ? CH_DEL : 8'($urandom_range(0, 32)));
          default: put_byte(8'($urandom_range(33, 126)));
        endcase
      end
    end else begin
      n = $urandom_range(1, 5);
      repeat (n) begin
        case ($urandom_range(0, 7))
          0, 1, 2: begin
            put_byte(CH_PCT);
            put_byte(hex_glyph(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
            put_byte(hex_glyph(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
          end
          3: begin
            put_byte(CH_PCT);
            put_byte(8'($urandom_range(0, 255)));
            put_byte(8'($urandom_range(0, 255)));
          end
          4: put_byte(CH_PLUS);
          5, 6: put_byte(8'($urandom_range(32, 126)));
          default: put_byte(8'($urandom_range(0, 255)));
        endcase
      end
      // short escape at the end of the string
      case ($urandom_range(0, 5))
        0: put_byte(CH_PCT);
        1: begin
          put_byte(CH_PCT);
          put_byte(8'($urandom_range(0, 255)));
        end
        default: ;
      endcase
    end
  endtask

  // ------------------------------------------------------------------ main

  initial begin : stim
    int phase;
    int n_str;
    bit chop;
    logic d;
    logic [2:0] c;

    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_DIRECTION;
    cfg_data      <= 3'd0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    fix_on        <= 1'b0;
    fix_n         <= 2'd0;
    fix_bytes     <= 24'h0;
    drv_dir  = DIR_ENCODE;
    drv_comp = COMP_USERINFO;

    // expected bytes are written last-first: "00%" is '%' '0' '0'
    rows[0]  = '{DIR_ENCODE, COMP_USERINFO, "a",   1'b0, 1'b1, 2'd1, 24'h61};
    rows[1]  = '{DIR_ENCODE, COMP_USERINFO, 8'h00, 1'b0, 1'b1, 2'd3, "00%"};
    rows[2]  = '{DIR_ENCODE, COMP_USERINFO, 8'hFF, 1'b0, 1'b1, 2'd1, 24'hFF};
    rows[3]  = '{DIR_ENCODE, COMP_USERINFO, " ",   1'b0, 1'b1, 2'd3, "02%"};
    rows[4]  = '{DIR_ENCODE, COMP_USERINFO, 8'h7F, 1'b1, 1'b1, 2'd3, "F7%"};
    rows[5]  = '{DIR_ENCODE, COMP_HOST,     "[",   1'b0, 1'b1, 2'd1, 24'h5B};
    rows[6]  = '{DIR_ENCODE, COMP_HOST,     "@",   1'b1, 1'b1, 2'd3, "04%"};
    rows[7]  = '{DIR_ENCODE, COMP_PATH,     "%",   1'b0, 1'b1, 2'd1, 24'h25};
    rows[8]  = '{DIR_ENCODE, COMP_PATH,     "~",   1'b1, 1'b0, 2'd0, 24'h0};
    rows[9]  = '{DIR_ENCODE, COMP_QUERY,    "&",   1'b0, 1'b1, 2'd1, 24'h26};
    rows[10] = '{DIR_ENCODE, COMP_QUERY,    "=",   1'b1, 1'b0, 2'd0, 24'h0};
    rows[11] = '{DIR_ENCODE, COMP_FRAGMENT, "#",   1'b1, 1'b1, 2'd3, "32%"};
    rows[12] = '{DIR_ENCODE, 3'd7,          ":",   1'b1, 1'b1, 2'd3, "A3%"};
    rows[13] = '{DIR_DECODE, COMP_USERINFO, "+",   1'b0, 1'b1, 2'd1, 24'h20};
    rows[14] = '{DIR_DECODE, COMP_USERINFO, "%",   1'b0, 1'b1, 2'd0, 24'h0};
    rows[15] = '{DIR_DECODE, COMP_USERINFO, "4",   1'b0, 1'b1, 2'd0, 24'h0};
    rows[16] = '{DIR_DECODE, COMP_USERINFO, "1",   1'b0, 1'b1, 2'd1, 24'h41};
    // %0a is a control byte: dropped, so the string ends on an empty beat
    rows[17] = '{DIR_DECODE, COMP_USERINFO, "%",   1'b0, 1'b0, 2'd0, 24'h0};
    rows[18] = '{DIR_DECODE, COMP_USERINFO, "0",   1'b0, 1'b0, 2'd0, 24'h0};
    rows[19] = '{DIR_DECODE, COMP_USERINFO, "a",   1'b1, 1'b1, 2'd0, 24'h0};
    // swallowed pair
    rows[20] = '{DIR_DECODE, COMP_USERINFO, "%",   1'b0, 1'b0, 2'd0, 24'h0};
    rows[21] = '{DIR_DECODE, COMP_USERINFO, "G",   1'b0, 1'b0, 2'd0, 24'h0};
    rows[22] = '{DIR_DECODE, COMP_USERINFO, "f",   1'b0, 1'b0, 2'd0, 24'h0};
    // '%' one byte before the end, then '%' as the very last byte
    rows[23] = '{DIR_DECODE, COMP_USERINFO, "%",   1'b0, 1'b0, 2'd0, 24'h0};
    rows[24] = '{DIR_DECODE, COMP_USERINFO, "%",   1'b1, 1'b1, 2'd2, "%%"};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (rows[i].dir != drv_dir || rows[i].comp != drv_comp) begin
        settle();
        set_mode({2'b00, rows[i].dir}, rows[i].comp);
      end
      send_beat(rows[i].b, rows[i].l, rows[i].fixed, rows[i].n, rows[i].e);
    end

    phase = 0;
    while (sent < TOTAL_BYTES) begin
      settle();
      case (phase)
        0: begin d = DIR_ENCODE; c = COMP_USERINFO; end
        1: begin d = DIR_DECODE; c = 3'd7;          end
        2: begin d = DIR_ENCODE; c = 3'd7;          end
        3: begin d = DIR_DECODE; c = COMP_USERINFO; end
        4: begin d = DIR_ENCODE; c = 3'($urandom_range(0, 7)); end
        default: begin
          d = 1'($urandom_range(0, 1));
          c = 3'($urandom_range(0, 7));
        end
      endcase
      set_mode({2'($urandom_range(0, 3)), d}, c);
      // long output hold-off while the input keeps pushing
      if (phase == 4) begin
        idle_on  = 1'b0;
        hold_req = 1'b1;
      end
      n_str = $urandom_range(2, 6);
      for (int s = 0; s < n_str; s++) begin
        fill_string(d);
        // sometimes leave a string open across the next config change
        chop = (s == n_str - 1) && ($urandom_range(0, 3) == 0);
        for (int k = 0; k < str_q.size(); k++)
          send_beat(str_q[k], (k == str_q.size() - 1) && !chop, 1'b0, 2'd0, 24'h0);
      end
      idle_on = (sent < TOTAL_BYTES - 70);
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (beats_due.size() != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("uri_percent_codec_tb OK");
    end else begin
      $display("uri_percent_codec_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/upc_pkg.sv
hw/rtl/uri_percent_codec.sv
tb/uri_percent_codec_tb.sv
